// ===== hdl/lsw_pkg.sv =====
// Shared constants, codes and interface structs of the LED display serial writer.
`timescale 1ns / 1ps

package lsw_pkg;

    // Frame geometry
    localparam int FRAME_BYTES = 16;               // bytes sent after the address command
    localparam int IDX_W       = 4;                // frame index width
    localparam int FRAME_DEPTH = 1 << IDX_W;       // rows of frame storage
    localparam int CNT_W       = IDX_W + 1;        // byte counter, can exceed the frame
    localparam int BYTE_W      = 8;
    localparam int BIT_W       = 3;                // bit position within a byte
    localparam int TICK_W      = 8;
    localparam int SLOTS       = 2;                // two storage slots per frame byte

    // Configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [BYTE_W-1:0] ADDR_CMD_RESET = 8'hC0;
    localparam logic [TICK_W-1:0] TPP_RESET      = 8'h01;

    // Item kinds; the fourth code does nothing
    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_COMMAND = 2'd1,
        KIND_TICK    = 2'd2
    } t_kind;

    // Register indexes of the configuration port
    typedef enum logic {
        REG_ADDRESS_COMMAND = 1'b0,
        REG_TICKS_PER_PHASE = 1'b1
    } t_reg_idx;

    // Line phases of the serial link
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START_A  = 4'd1,
        PH_START_B  = 4'd2,
        PH_START_C  = 4'd3,
        PH_BIT_LOW  = 4'd4,
        PH_BIT_DATA = 4'd5,
        PH_BIT_HIGH = 4'd6,
        PH_STOP_A   = 4'd7,
        PH_STOP_B   = 4'd8
    } t_phase;

    // Frame store read request, issued in the accept cycle
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } t_store_rd;

    // Frame store update, issued when an item completes
    typedef struct packed {
        logic              load;     // write staged byte
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] val;
        logic              commit;   // staged frame becomes the sent frame
    } t_store_ctl;

    // Link sequencer control
    typedef struct packed {
        logic              start;
        logic              single;
        logic [BYTE_W-1:0] first_byte;
        logic              tick;
    } t_seq_ctl;

    // Link sequencer status: current busy and line levels after this cycle
    typedef struct packed {
        logic busy;
        logic n_busy;
        logic n_clock;
        logic n_data;
    } t_seq_stat;

endpackage

// ===== hdl/lsw_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module lsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/lsw_frame_store.sv =====
// Staged and sent frame storage: two slots per byte, slot pointers and change tracking.
`timescale 1ns / 1ps

module lsw_frame_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lsw_pkg::t_store_rd        i_rd,
    input  lsw_pkg::t_store_ctl       i_ctl,
    input  logic [lsw_pkg::IDX_W-1:0] i_tx_idx,
    output logic                      o_same,
    output logic [lsw_pkg::BYTE_W-1:0] o_tx_byte
);

    // Per-row state: which slot holds the sent byte, whether the staged byte
    // lives in the other slot, whether staged differs from sent, slot written
    logic [lsw_pkg::FRAME_DEPTH-1:0]                      r_se, n_se;
    logic [lsw_pkg::FRAME_DEPTH-1:0]                      r_sep, n_sep;
    logic [lsw_pkg::FRAME_DEPTH-1:0]                      r_diff, n_diff, diff_ld;
    logic [lsw_pkg::SLOTS-1:0][lsw_pkg::FRAME_DEPTH-1:0]  r_vld, n_vld;

    // Last write, forwarded to a read that raced it
    logic                       r_fw_valid;
    logic [lsw_pkg::IDX_W-1:0]  r_fw_row;
    logic                       r_fw_slot;
    logic [lsw_pkg::BYTE_W-1:0] r_fw_data;

    logic [lsw_pkg::SLOTS-1:0][lsw_pkg::BYTE_W-1:0] cmp_q;
    logic [lsw_pkg::SLOTS-1:0][lsw_pkg::BYTE_W-1:0] tx_q;
    logic [lsw_pkg::SLOTS-1:0]                      ram_we;

    logic                       se_b;
    logic                       w_slot;
    logic                       fwd_hit;
    logic [lsw_pkg::BYTE_W-1:0] sent_raw;
    logic [lsw_pkg::BYTE_W-1:0] sent_val;
    logic                       se_t;

    // Compare port RAMs read the loaded row, transmit port RAMs the next byte to send
    for (genvar s = 0; s < lsw_pkg::SLOTS; s++) begin : g_slot
        assign ram_we[s] = i_ctl.load && (w_slot == 1'(s));

        lsw_ram #(
            .WIDTH (lsw_pkg::BYTE_W),
            .DEPTH (lsw_pkg::FRAME_DEPTH)
        ) u_cmp_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we[s]),
            .i_waddr (i_ctl.idx),
            .i_wdata (i_ctl.val),
            .i_re    (i_rd.en),
            .i_raddr (i_rd.idx),
            .o_rdata (cmp_q[s])
        );

        lsw_ram #(
            .WIDTH (lsw_pkg::BYTE_W),
            .DEPTH (lsw_pkg::FRAME_DEPTH)
        ) u_tx_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we[s]),
            .i_waddr (i_ctl.idx),
            .i_wdata (i_ctl.val),
            .i_re    (1'b1),
            .i_raddr (i_tx_idx),
            .o_rdata (tx_q[s])
        );
    end

    // Sent byte of the loaded row; loads always write the slot not holding it
    always_comb begin
        se_b     = r_se[i_ctl.idx];
        w_slot   = ~se_b;
        fwd_hit  = r_fw_valid && (r_fw_row == i_ctl.idx) && (r_fw_slot == se_b);
        sent_raw = fwd_hit ? r_fw_data : cmp_q[se_b];
        sent_val = r_vld[se_b][i_ctl.idx] ? sent_raw : '0;
    end

    // Pointer and change-flag update
    always_comb begin
        diff_ld = r_diff;
        n_sep   = r_sep;
        n_vld   = r_vld;
        if (i_ctl.load) begin
            diff_ld[i_ctl.idx]       = (i_ctl.val != sent_val);
            n_sep[i_ctl.idx]         = 1'b1;
            n_vld[w_slot][i_ctl.idx] = 1'b1;
        end
        n_se   = r_se;
        n_diff = diff_ld;
        if (i_ctl.commit) begin
            n_se   = r_se ^ n_sep;
            n_sep  = '0;
            n_diff = '0;
        end
    end

    assign o_same = ~|diff_ld;

    // Transmit byte: sent slot of the current byte, zero if never written
    always_comb begin
        se_t      = r_se[i_tx_idx];
        o_tx_byte = r_vld[se_t][i_tx_idx] ? tx_q[se_t] : '0;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_se       <= '0;
            r_sep      <= '0;
            r_diff     <= '0;
            r_vld      <= '0;
            r_fw_valid <= 1'b0;
        end else begin
            r_se   <= n_se;
            r_sep  <= n_sep;
            r_diff <= n_diff;
            r_vld  <= n_vld;
            if (i_ctl.load) begin
                r_fw_valid <= 1'b1;
            end
        end
    end

    // Forwarding payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_fw_row  <= i_ctl.idx;
            r_fw_slot <= w_slot;
            r_fw_data <= i_ctl.val;
        end
    end

endmodule

// ===== hdl/lsw_link_seq.sv =====
// Link phase sequencer: start, LSB-first bytes and stop on the clock and data lines.
`timescale 1ns / 1ps

module lsw_link_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lsw_pkg::t_seq_ctl           i_ctl,
    input  logic [lsw_pkg::TICK_W-1:0]  i_ticks_per_phase,
    input  logic [lsw_pkg::BYTE_W-1:0]  i_tx_byte,
    output logic [lsw_pkg::IDX_W-1:0]   o_tx_idx,
    output lsw_pkg::t_seq_stat          o_stat
);

    lsw_pkg::t_phase             r_phase, n_phase;
    logic [lsw_pkg::BIT_W-1:0]   r_bit_count, n_bit_count;
    logic [lsw_pkg::CNT_W-1:0]   r_byte_count, n_byte_count;
    logic [lsw_pkg::BYTE_W-1:0]  r_shift, n_shift;
    logic [lsw_pkg::TICK_W-1:0]  r_phase_ticks, n_phase_ticks;
    logic                        r_single, n_single;
    logic                        r_clock, n_clock;
    logic                        r_data, n_data;

    logic                        busy;
    logic [lsw_pkg::TICK_W-1:0]  limit;
    logic [lsw_pkg::TICK_W-1:0]  tick_inc;
    logic                        adv;
    logic [lsw_pkg::CNT_W-1:0]   bc_inc;
    logic                        last_bit;
    logic                        done;

    // Phase timing
    always_comb begin
        busy     = (r_phase != lsw_pkg::PH_IDLE);
        limit    = (i_ticks_per_phase == '0) ? lsw_pkg::TICK_W'(1) : i_ticks_per_phase;
        tick_inc = r_phase_ticks + lsw_pkg::TICK_W'(1);
        adv      = i_ctl.tick && busy && (tick_inc >= limit);
        bc_inc   = r_byte_count + lsw_pkg::CNT_W'(1);
        last_bit = (r_bit_count == '1);
        done     = r_single || (bc_inc > lsw_pkg::CNT_W'(lsw_pkg::FRAME_BYTES));
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_ctl.start) begin
            n_phase = lsw_pkg::PH_START_A;
        end else if (adv) begin
            unique case (r_phase)
                lsw_pkg::PH_START_A:  n_phase = lsw_pkg::PH_START_B;
                lsw_pkg::PH_START_B:  n_phase = lsw_pkg::PH_START_C;
                lsw_pkg::PH_START_C:  n_phase = lsw_pkg::PH_BIT_LOW;
                lsw_pkg::PH_BIT_LOW:  n_phase = lsw_pkg::PH_BIT_DATA;
                lsw_pkg::PH_BIT_DATA: n_phase = lsw_pkg::PH_BIT_HIGH;
                lsw_pkg::PH_BIT_HIGH: begin
                    if (!last_bit || !done) begin
                        n_phase = lsw_pkg::PH_BIT_LOW;
                    end else begin
                        n_phase = lsw_pkg::PH_STOP_A;
                    end
                end
                lsw_pkg::PH_STOP_A:   n_phase = lsw_pkg::PH_STOP_B;
                default:              n_phase = lsw_pkg::PH_IDLE;
            endcase
        end
    end

    // Line levels, shifter and counters
    always_comb begin
        n_bit_count   = r_bit_count;
        n_byte_count  = r_byte_count;
        n_shift       = r_shift;
        n_phase_ticks = r_phase_ticks;
        n_single      = r_single;
        n_clock       = r_clock;
        n_data        = r_data;
        if (i_ctl.start) begin
            n_single      = i_ctl.single;
            n_shift       = i_ctl.first_byte;
            n_bit_count   = '0;
            n_byte_count  = '0;
            n_phase_ticks = '0;
            n_clock       = 1'b1;
            n_data        = 1'b1;
        end else if (i_ctl.tick && busy) begin
            n_phase_ticks = adv ? '0 : tick_inc;
            if (adv) begin
                unique case (r_phase)
                    lsw_pkg::PH_START_A: n_data = 1'b0;
                    lsw_pkg::PH_START_B: n_clock = 1'b0;
                    lsw_pkg::PH_START_C: begin
                        n_clock = 1'b0;
                        n_data  = 1'b0;
                    end
                    lsw_pkg::PH_BIT_LOW:  n_data = r_shift[0];
                    lsw_pkg::PH_BIT_DATA: n_clock = 1'b1;
                    lsw_pkg::PH_BIT_HIGH: begin
                        if (!last_bit) begin
                            n_bit_count = r_bit_count + lsw_pkg::BIT_W'(1);
                            n_shift     = r_shift >> 1;
                            n_clock     = 1'b0;
                        end else begin
                            n_bit_count  = '0;
                            n_byte_count = bc_inc;
                            n_data       = 1'b0;
                            if (done) begin
                                n_clock = 1'b1;
                            end else begin
                                n_shift = i_tx_byte;
                                n_clock = 1'b0;
                            end
                        end
                    end
                    lsw_pkg::PH_STOP_A: n_data = 1'b1;
                    default: begin
                        n_clock = 1'b1;
                        n_data  = 1'b1;
                    end
                endcase
            end
        end
    end

    // Next byte to send is frame byte byte_count, fetched ahead from the transmit RAM
    assign o_tx_idx = r_byte_count[lsw_pkg::IDX_W-1:0];

    always_comb begin
        o_stat.busy    = busy;
        o_stat.n_busy  = (n_phase != lsw_pkg::PH_IDLE);
        o_stat.n_clock = n_clock;
        o_stat.n_data  = n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= lsw_pkg::PH_IDLE;
            r_bit_count   <= '0;
            r_byte_count  <= '0;
            r_shift       <= '0;
            r_phase_ticks <= '0;
            r_single      <= 1'b0;
            r_clock       <= 1'b1;
            r_data        <= 1'b1;
        end else begin
            r_phase       <= n_phase;
            r_bit_count   <= n_bit_count;
            r_byte_count  <= n_byte_count;
            r_shift       <= n_shift;
            r_phase_ticks <= n_phase_ticks;
            r_single      <= n_single;
            r_clock       <= n_clock;
            r_data        <= n_data;
        end
    end

endmodule

// ===== hdl/led_display_serial_writer_top.sv =====
// Top level of the LED display serial writer: item pipeline, registers, result register.
//
// Usage: items enter on the input channel (i_in_valid / o_in_stall) and each
// produces exactly one result transaction on the output channel (o_out_valid /
// i_out_stall) with the line levels, busy flag and the rejected / skipped flags.
// Load items write a staged frame byte; a load with frame end set commits the
// frame, which is sent unless it equals the frame last sent. Command items send
// one framed byte. Tick items advance the link by one line phase every
// ticks_per_phase ticks. Registers are written through the APB port.
// Path: the frame store read is registered together with the item in the completion
// stage, and the result is then captured in the result register.
// Throughput: one item per cycle while the output is not stalled, set by the
// read-modify-write of the frame store and link sequencer in the completion stage.
// Reset: synchronous, active low; the lines idle high, the staged frame reads
// as zero through per-entry valid bits, no clearing pass is needed.
// Stall: a stalled result is held; one more item is accepted into the completion
// stage, after which o_in_stall rises until the result is taken.
`timescale 1ns / 1ps

module led_display_serial_writer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_kind,
    input  logic [lsw_pkg::IDX_W-1:0]      i_byte_index,
    input  logic [lsw_pkg::BYTE_W-1:0]     i_byte_value,
    input  logic                           i_frame_end,
    // Output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_clock_line,
    output logic                           o_data_line,
    output logic                           o_busy_res,
    output logic                           o_rejected,
    output logic                           o_skipped,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lsw_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lsw_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lsw_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    // Configuration registers
    logic [lsw_pkg::BYTE_W-1:0] r_address_command;
    logic [lsw_pkg::TICK_W-1:0] r_ticks_per_phase;
    logic                       cfg_we;
    lsw_pkg::t_reg_idx          cfg_idx;

    // Completion stage
    logic                       r_b_valid;
    logic [1:0]                 r_b_kind;
    logic [lsw_pkg::IDX_W-1:0]  r_b_idx;
    logic [lsw_pkg::BYTE_W-1:0] r_b_val;
    logic                       r_b_fend;

    // Result register
    logic r_o_valid;
    logic r_o_clock;
    logic r_o_data;
    logic r_o_busy;
    logic r_o_rej;
    logic r_o_skip;

    logic r_sent_once;

    logic in_accept;
    logic out_take;
    logic b_fire;
    logic is_load;
    logic is_cmd;
    logic is_tick;
    logic idx_ok;
    logic commit_req;
    logic commit;
    logic cmd_start;
    logic rej;
    logic skip;
    logic same;

    lsw_pkg::t_store_rd          store_rd;
    lsw_pkg::t_store_ctl         store_ctl;
    lsw_pkg::t_seq_ctl           seq_ctl;
    lsw_pkg::t_seq_stat          seq_stat;
    logic [lsw_pkg::IDX_W-1:0]   tx_idx;
    logic [lsw_pkg::BYTE_W-1:0]  tx_byte;

    // APB register access
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = lsw_pkg::t_reg_idx'(paddr[lsw_pkg::APB_ADDR_W-1]);

    always_comb begin
        unique case (cfg_idx)
            lsw_pkg::REG_ADDRESS_COMMAND: prdata = lsw_pkg::APB_DATA_W'(r_address_command);
            lsw_pkg::REG_TICKS_PER_PHASE: prdata = lsw_pkg::APB_DATA_W'(r_ticks_per_phase);
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address_command <= lsw_pkg::ADDR_CMD_RESET;
            r_ticks_per_phase <= lsw_pkg::TPP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                lsw_pkg::REG_ADDRESS_COMMAND: r_address_command <= pwdata[lsw_pkg::BYTE_W-1:0];
                lsw_pkg::REG_TICKS_PER_PHASE: r_ticks_per_phase <= pwdata[lsw_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: completion stage advances when the result register is free
    assign out_take   = r_o_valid && !i_out_stall;
    assign b_fire     = r_b_valid && (!r_o_valid || out_take);
    assign o_in_stall = r_b_valid && !b_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Kind decode
    always_comb begin
        is_load = 1'b0;
        is_cmd  = 1'b0;
        is_tick = 1'b0;
        unique case (lsw_pkg::t_kind'(r_b_kind))
            lsw_pkg::KIND_LOAD:    is_load = 1'b1;
            lsw_pkg::KIND_COMMAND: is_cmd  = 1'b1;
            lsw_pkg::KIND_TICK:    is_tick = 1'b1;
            default: ;
        endcase
    end

    // Commit, command and flag decisions
    always_comb begin
        idx_ok     = ({1'b0, r_b_idx} < lsw_pkg::CNT_W'(lsw_pkg::FRAME_BYTES));
        commit_req = b_fire && is_load && r_b_fend;
        skip       = commit_req && !seq_stat.busy && r_sent_once && same;
        commit     = commit_req && !seq_stat.busy && !(r_sent_once && same);
        cmd_start  = b_fire && is_cmd && !seq_stat.busy;
        rej        = b_fire && seq_stat.busy && ((is_load && r_b_fend) || is_cmd);
    end

    always_comb begin
        store_rd.en      = in_accept;
        store_rd.idx     = i_byte_index;
        store_ctl.load   = b_fire && is_load && idx_ok;
        store_ctl.idx    = r_b_idx;
        store_ctl.val    = r_b_val;
        store_ctl.commit = commit;
        seq_ctl.start      = commit || cmd_start;
        seq_ctl.single     = cmd_start;
        seq_ctl.first_byte = cmd_start ? r_b_val : r_address_command;
        seq_ctl.tick       = b_fire && is_tick;
    end

    lsw_frame_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (store_rd),
        .i_ctl     (store_ctl),
        .i_tx_idx  (tx_idx),
        .o_same    (same),
        .o_tx_byte (tx_byte)
    );

    lsw_link_seq u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (seq_ctl),
        .i_ticks_per_phase (r_ticks_per_phase),
        .i_tx_byte         (tx_byte),
        .o_tx_idx          (tx_idx),
        .o_stat            (seq_stat)
    );

    // Pipeline control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_o_valid   <= 1'b0;
            r_sent_once <= 1'b0;
        end else begin
            if (in_accept) begin
                r_b_valid <= 1'b1;
            end else if (b_fire) begin
                r_b_valid <= 1'b0;
            end
            if (b_fire) begin
                r_o_valid <= 1'b1;
            end else if (out_take) begin
                r_o_valid <= 1'b0;
            end
            if (commit) begin
                r_sent_once <= 1'b1;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_b_kind <= i_kind;
            r_b_idx  <= i_byte_index;
            r_b_val  <= i_byte_value;
            r_b_fend <= i_frame_end;
        end
        if (b_fire) begin
            r_o_clock <= seq_stat.n_clock;
            r_o_data  <= seq_stat.n_data;
            r_o_busy  <= seq_stat.n_busy;
            r_o_rej   <= rej;
            r_o_skip  <= skip;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_clock_line = r_o_clock;
    assign o_data_line  = r_o_data;
    assign o_busy_res   = r_o_busy;
    assign o_rejected   = r_o_rej;
    assign o_skipped    = r_o_skip;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the LED display serial writer: line sequencing, flags, registers.
`timescale 1ns / 1ps

module tb;

    // Fourth item kind, accepted and ignored by the block
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic clock_line;
        logic data_line;
        logic busy;
        logic rejected;
        logic skipped;
    } t_line_result;

    // Scoreboard: predicts the line levels and flags of every transaction
    class display_link_scoreboard;
        logic [7:0]        addr_cmd;
        logic [7:0]        tpp;
        logic [15:0][7:0]  staged;
        logic [15:0][7:0]  sent;
        bit                sent_once;
        lsw_pkg::t_phase   phase;
        logic [2:0]        bit_cnt;
        logic [4:0]        byte_cnt;
        logic [7:0]        shift_reg;
        logic [7:0]        tick_cnt;
        bit                single_cmd;
        bit                clk_lvl;
        bit                dat_lvl;
        t_line_result      expected_q[$];
        int                errors;

        function new();
            addr_cmd   = lsw_pkg::ADDR_CMD_RESET;
            tpp        = lsw_pkg::TPP_RESET;
            staged     = '0;
            sent       = '0;
            sent_once  = 1'b0;
            phase      = lsw_pkg::PH_IDLE;
            bit_cnt    = '0;
            byte_cnt   = '0;
            shift_reg  = '0;
            tick_cnt   = '0;
            single_cmd = 1'b0;
            clk_lvl    = 1'b1;
            dat_lvl    = 1'b1;
            errors     = 0;
        endfunction

        function void set_register(lsw_pkg::t_reg_idx r, logic [7:0] v);
            if (r == lsw_pkg::REG_ADDRESS_COMMAND) addr_cmd = v;
            else tpp = v;
        endfunction

        function void start_link(logic [7:0] first, bit single);
            single_cmd = single;
            shift_reg  = first;
            bit_cnt    = '0;
            byte_cnt   = '0;
            tick_cnt   = '0;
            phase      = lsw_pkg::PH_START_A;
            clk_lvl    = 1'b1;
            dat_lvl    = 1'b1;
        endfunction

        // One line phase of start, bit, byte boundary or stop sequencing
        function void advance_phase();
            case (phase)
                lsw_pkg::PH_START_A: begin
                    dat_lvl = 1'b0;
                    phase   = lsw_pkg::PH_START_B;
                end
                lsw_pkg::PH_START_B: begin
                    clk_lvl = 1'b0;
                    phase   = lsw_pkg::PH_START_C;
                end
                lsw_pkg::PH_START_C: begin
                    clk_lvl = 1'b0;
                    dat_lvl = 1'b0;
                    phase   = lsw_pkg::PH_BIT_LOW;
                end
                lsw_pkg::PH_BIT_LOW: begin
                    dat_lvl = shift_reg[0];
                    phase   = lsw_pkg::PH_BIT_DATA;
                end
                lsw_pkg::PH_BIT_DATA: begin
                    clk_lvl = 1'b1;
                    phase   = lsw_pkg::PH_BIT_HIGH;
                end
                lsw_pkg::PH_BIT_HIGH: begin
                    if (bit_cnt < 3'd7) begin
                        bit_cnt   = bit_cnt + 3'd1;
                        shift_reg = shift_reg >> 1;
                        clk_lvl   = 1'b0;
                        phase     = lsw_pkg::PH_BIT_LOW;
                    end else begin
                        bit_cnt  = '0;
                        byte_cnt = byte_cnt + 5'd1;
                        if (single_cmd || byte_cnt > lsw_pkg::FRAME_BYTES) begin
                            clk_lvl = 1'b1;
                            dat_lvl = 1'b0;
                            phase   = lsw_pkg::PH_STOP_A;
                        end else begin
                            shift_reg = sent[4'(byte_cnt - 5'd1)];
                            clk_lvl   = 1'b0;
                            dat_lvl   = 1'b0;
                            phase     = lsw_pkg::PH_BIT_LOW;
                        end
                    end
                end
                lsw_pkg::PH_STOP_A: begin
                    dat_lvl = 1'b1;
                    phase   = lsw_pkg::PH_STOP_B;
                end
                default: begin
                    clk_lvl = 1'b1;
                    dat_lvl = 1'b1;
                    phase   = lsw_pkg::PH_IDLE;
                end
            endcase
        endfunction

        // Accepted input transaction: update state, queue the expected result
        function void note_input(logic [1:0] kind, logic [3:0] idx, logic [7:0] val,
                                 logic fend);
            t_line_result r;
            bit           busy_now;
            logic [7:0]   limit;
            r        = '0;
            busy_now = (phase != lsw_pkg::PH_IDLE);
            case (kind)
                lsw_pkg::KIND_LOAD: begin
                    staged[idx] = val;
                    if (fend) begin
                        if (busy_now) begin
                            r.rejected = 1'b1;
                        end else if (sent_once && staged == sent) begin
                            r.skipped = 1'b1;
                        end else begin
                            sent_once = 1'b1;
                            sent      = staged;
                            start_link(addr_cmd, 1'b0);
                        end
                    end
                end
                lsw_pkg::KIND_COMMAND: begin
                    if (busy_now) r.rejected = 1'b1;
                    else start_link(val, 1'b1);
                end
                lsw_pkg::KIND_TICK: begin
                    if (busy_now) begin
                        // zero ticks per phase behaves as one
                        limit    = (tpp == 8'd0) ? 8'd1 : tpp;
                        tick_cnt = tick_cnt + 8'd1;
                        if (tick_cnt >= limit) begin
                            tick_cnt = '0;
                            advance_phase();
                        end
                    end
                end
                default: ;
            endcase
            r.clock_line = clk_lvl;
            r.data_line  = dat_lvl;
            r.busy       = (phase != lsw_pkg::PH_IDLE);
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic want, logic got);
            if (got !== want) begin
                $display("%0t ERROR %s: expected %b, got %b", $time, name, want, got);
                errors++;
            end
        endfunction

        // Accepted output transaction against the oldest expectation
        function void check_result(t_line_result got);
            t_line_result want;
            if (expected_q.size() == 0) begin
                $display("%0t ERROR result with nothing expected: %b", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("clock_line", want.clock_line, got.clock_line);
            compare_field("data_line", want.data_line, got.data_line);
            compare_field("busy_res", want.busy, got.busy);
            compare_field("rejected", want.rejected, got.rejected);
            compare_field("skipped", want.skipped, got.skipped);
        endfunction
    endclass

    logic                             i_clk        = 1'b0;
    logic                             i_rst_n      = 1'b0;
    logic                             i_in_valid   = 1'b0;
    logic                             o_in_stall;
    logic [1:0]                       i_kind       = '0;
    logic [lsw_pkg::IDX_W-1:0]        i_byte_index = '0;
    logic [lsw_pkg::BYTE_W-1:0]       i_byte_value = '0;
    logic                             i_frame_end  = 1'b0;
    logic                             o_out_valid;
    logic                             i_out_stall  = 1'b0;
    logic                             o_clock_line;
    logic                             o_data_line;
    logic                             o_busy_res;
    logic                             o_rejected;
    logic                             o_skipped;
    logic                             psel         = 1'b0;
    logic                             penable      = 1'b0;
    logic                             pwrite       = 1'b0;
    logic [lsw_pkg::APB_ADDR_W-1:0]   paddr        = '0;
    logic [lsw_pkg::APB_DATA_W-1:0]   pwdata       = '0;
    logic [lsw_pkg::APB_DATA_W-1:0]   prdata;
    logic                             pready;

    display_link_scoreboard  sb;
    bit                      steady = 1'b0;   // no idling on either side while set

    led_display_serial_writer_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_byte_index (i_byte_index),
        .i_byte_value (i_byte_value),
        .i_frame_end  (i_frame_end),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_clock_line (o_clock_line),
        .o_data_line  (o_data_line),
        .o_busy_res   (o_busy_res),
        .o_rejected   (o_rejected),
        .o_skipped    (o_skipped),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 i_clk = ~i_clk;

    // Result side: random stall, check every accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall)
                sb.check_result(t_line_result'({o_clock_line, o_data_line, o_busy_res,
                                                o_rejected, o_skipped}));
            i_out_stall <= steady ? 1'b0 : ($urandom_range(99) < 21);
        end
    end

    // Present one item, hold it until accepted
    task automatic push_item(logic [1:0] k, logic [3:0] ix, logic [7:0] v, logic fe);
        if (!steady && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= k;
        i_byte_index <= ix;
        i_byte_value <= v;
        i_frame_end  <= fe;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(k, ix, v, fe);
    endtask

    // Register write followed by a read back
    task automatic write_register(lsw_pkg::t_reg_idx r, logic [7:0] v);
        logic [lsw_pkg::APB_DATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lsw_pkg::APB_ADDR_W'(4 * int'(r));
        pwdata  <= lsw_pkg::APB_DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(r, v);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== lsw_pkg::APB_DATA_W'(v)) begin
            $display("%0t ERROR register %0d read: expected %h, got %h", $time, r, v, rd);
            sb.errors++;
        end
        @(posedge i_clk);
    endtask

    // Item for a busy link: mostly ticks, else items that are rejected or
    // leave the staged frame as it is
    task automatic random_item();
        int          r;
        logic [1:0]  k;
        logic [3:0]  ix;
        logic [7:0]  v;
        logic        fe;
        r  = int'($urandom_range(99));
        ix = 4'($urandom_range(15));
        v  = sb.staged[ix];
        fe = 1'($urandom_range(1));
        if (r < 90)      k = lsw_pkg::KIND_TICK;
        else if (r < 95) k = lsw_pkg::KIND_LOAD;
        else if (r < 98) k = lsw_pkg::KIND_COMMAND;
        else             k = KIND_UNUSED;
        push_item(k, ix, v, fe);
    endtask

    // Tick the link back to idle
    task automatic finish_link();
        while (sb.phase != lsw_pkg::PH_IDLE) random_item();
    endtask

    // All results in and the block quiet before touching registers
    task automatic settle();
        finish_link();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] frame_bytes [16];
        sb = new();
        for (int i = 0; i < 16; i++)
            frame_bytes[i] = 8'($urandom_range(255));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Random address command for the frames
        write_register(lsw_pkg::REG_ADDRESS_COMMAND, 8'($urandom_range(255)));

        // Ignored kind and a tick on the idle link
        push_item(KIND_UNUSED, 4'hF, 8'hFF, 1'b1);
        push_item(lsw_pkg::KIND_TICK, 4'h0, 8'h00, 1'b0);

        // Fill the frame and commit it: the first frame always goes out
        for (int i = 0; i < 16; i++)
            push_item(lsw_pkg::KIND_LOAD, 4'(i), frame_bytes[i], 1'(i == 15));

        // While busy: command and commit are rejected, the load still lands
        push_item(lsw_pkg::KIND_COMMAND, 4'h0, 8'hA5, 1'b0);
        push_item(lsw_pkg::KIND_LOAD, 4'h3, ~frame_bytes[3], 1'b1);
        push_item(KIND_UNUSED, 4'h0, 8'h00, 1'b0);

        // Long stretch without idling on either side
        steady = 1'b1;
        repeat (150) random_item();
        steady = 1'b0;
        finish_link();

        // Restoring the changed byte makes the frame equal to the one sent
        push_item(lsw_pkg::KIND_LOAD, 4'h3, frame_bytes[3], 1'b1);
        settle();

        // Command byte with two ticks per phase
        write_register(lsw_pkg::REG_TICKS_PER_PHASE, 8'h02);
        push_item(lsw_pkg::KIND_COMMAND, 4'h0, 8'($urandom_range(255)), 1'b0);
        settle();

        // Zero ticks per phase runs as one; a changed frame goes out again
        // and the run ends partway into its second frame byte
        write_register(lsw_pkg::REG_TICKS_PER_PHASE, 8'h00);
        push_item(lsw_pkg::KIND_LOAD, 4'h1, ~frame_bytes[1], 1'b0);
        push_item(lsw_pkg::KIND_LOAD, 4'h0, ~frame_bytes[0], 1'b1);
        repeat (64) random_item();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);

        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("%0t ERROR timeout", $time);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
